FILE: hw/rtl/cbez_pkg.sv
// Shared types, widths and constants for the cubic Bezier point evaluator.
package cbez_pkg;

   // Curve resolution: u = i / STEPS
   localparam int STEPS = 200;

   // Field widths
   localparam int STEP_W  = 8;
   localparam int COORD_W = 16;
   localparam int PT_N    = 4;
   localparam int LANE_N  = 2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_X0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_Y0 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_X1 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_Y1 = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_X2 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_Y2 = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_X3 = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_X3_Y = 4'd7;

   // Weight arithmetic widths
   localparam longint DEN  = longint'(STEPS) * STEPS * STEPS;
   localparam int     IDX_W = $clog2(STEPS + 1);
   localparam int     SQ_W  = $clog2(STEPS * STEPS + 1);
   localparam int     AB_W  = SQ_W + 1;
   localparam int     W_W   = $clog2(DEN + 1);
   localparam int     P_W   = W_W + 1 + COORD_W;
   localparam int     NUM_W = P_W + 2;
   localparam int     T_W   = NUM_W + 2;

   // Rounding divide: 2*STEPS^3 = DIV_ODD << DIV_SHIFT
   localparam int     DIV_SHIFT = 10;
   localparam longint DIV_ODD   = 15625;
   localparam int     ODD_W     = $clog2(DIV_ODD + 1);
   localparam int     M_W       = COORD_W + ODD_W;
   localparam longint RECIP     = (longint'(1) << M_W) / DIV_ODD;
   localparam int     R_W       = $clog2(RECIP + 1);
   localparam int     Q_W       = COORD_W + 1;
   localparam int     QR_W      = Q_W + ODD_W;
   localparam longint Q_BIAS    = longint'(1) << (COORD_W - 1);
   localparam longint Q_OFF     = Q_BIAS * DIV_ODD;

   // Datapath types
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [PT_N-1:0]      ctrl_set_type;
   typedef ctrl_set_type [LANE_N-1:0] ctrl_pts_type;
   typedef logic [W_W-1:0]            weight_type;
   typedef weight_type [PT_N-1:0]     weights_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef num_type [LANE_N-1:0]      num_pair_type;
   typedef coord_type [LANE_N-1:0]    point_type;

endpackage

FILE: hw/rtl/cubic_bezier_point_eval.sv
// A req word runs through the weight, MAC and round stages, then the output register.
// Throughput: one point per cycle when rsp does not stall; every stage of the
// multiply/divide pipeline holds one word, so the rate is set by one word per
// register stage. Stalls on rsp back up stage by stage; bubbles are squeezed out.
// Reset (synchronous, active high) empties the pipeline and clears all
// eight control registers to zero.
module cubic_bezier_point_eval
   import cbez_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // step input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] step_index
   // point output
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [15:0] point_x, [31:16] point_y
   // control register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data
);

   ctrl_pts_type ctrl_in, ctrl_ff;
   logic         w_valid, w_ready;
   weights_type  weights;
   logic         m_valid, m_ready;
   num_pair_type num;
   logic         d_valid, d_ready;
   point_type    point;
   logic         rsp_tvalid_in, rsp_tvalid_ff;
   point_type    rsp_pt_ff;

   // Register writes are always taken; lane 0 is x, lane 1 is y
   assign csr_ready = 1'b1;

   always_comb begin
      ctrl_in = ctrl_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CTRL_X0:   ctrl_in[0][0] = csr_data;
            CSR_CTRL_Y0:   ctrl_in[1][0] = csr_data;
            CSR_CTRL_X1:   ctrl_in[0][1] = csr_data;
            CSR_CTRL_Y1:   ctrl_in[1][1] = csr_data;
            CSR_CTRL_X2:   ctrl_in[0][2] = csr_data;
            CSR_CTRL_Y2:   ctrl_in[1][2] = csr_data;
            CSR_CTRL_X3:   ctrl_in[0][3] = csr_data;
            CSR_CTRL_X3_Y: ctrl_in[1][3] = csr_data;
            default:       ctrl_in = ctrl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Weights from the step index
   cbez_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .step      (req_tdata[STEP_W-1:0]),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .weights   (weights)
   );

   // Weighted sums of the control points
   cbez_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (w_valid),
      .in_ready  (w_ready),
      .weights   (weights),
      .ctrl      (ctrl_ff),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .num       (num)
   );

   // Rounding divide by STEPS^3
   cbez_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .num       (num),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .point     (point)
   );

   // Output register: load when empty or when the current word is taken
   assign d_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (d_ready) begin
         rsp_tvalid_in = d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready && d_valid) begin
         rsp_pt_ff <= point;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_pt_ff[1], rsp_pt_ff[0]};

endmodule

FILE: hw/rtl/cbez_weight.sv
// Bernstein weight pipeline: saturate index, squares, cubes (three stages).
module cbez_weight
   import cbez_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [STEP_W-1:0] step,
   output logic              out_valid,
   input  logic              out_ready,
   output weights_type       weights
);

   logic                vld1_ff, vld2_ff, vld3_ff;
   logic                rdy1, rdy2, rdy3;
   logic [IDX_W-1:0]    b_in, b_ff, a_in, a_ff, b2s_ff, a2s_ff;
   logic [IDX_W+1:0]    a3_in, a3_ff;
   logic [SQ_W-1:0]     a2_in, a2_ff, b2_in, b2_ff;
   logic [AB_W-1:0]     ab3_in, ab3_ff;
   logic [2*IDX_W-1:0]  sq_a, sq_b;
   logic [2*IDX_W+1:0]  ab3_full;
   logic [SQ_W+IDX_W-1:0] cu0, cu3;
   logic [AB_W+IDX_W-1:0] cu1, cu2;
   weights_type         w_in, w_ff;

   // Stall chain: a stage loads when empty or when its successor loads
   assign rdy3     = !vld3_ff || out_ready;
   assign rdy2     = !vld2_ff || rdy3;
   assign rdy1     = !vld1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: clamp the index to STEPS, form a = S - b and 3a
   always_comb begin
      if (int'(step) > STEPS) begin
         b_in = IDX_W'(STEPS);
      end else begin
         b_in = IDX_W'(step);
      end
      a_in  = IDX_W'(STEPS) - b_in;
      a3_in = {2'b00, a_in} + {1'b0, a_in, 1'b0};
   end

   // Stage 2: a^2, b^2, 3ab
   always_comb begin
      sq_a     = a_ff * a_ff;
      sq_b     = b_ff * b_ff;
      ab3_full = a3_ff * b_ff;
      a2_in    = SQ_W'(sq_a);
      b2_in    = SQ_W'(sq_b);
      ab3_in   = AB_W'(ab3_full);
   end

   // Stage 3: the four cubic weights
   always_comb begin
      cu0     = a2_ff * a2s_ff;
      cu1     = ab3_ff * a2s_ff;
      cu2     = ab3_ff * b2s_ff;
      cu3     = b2_ff * b2s_ff;
      w_in[0] = W_W'(cu0);
      w_in[1] = W_W'(cu1);
      w_in[2] = W_W'(cu2);
      w_in[3] = W_W'(cu3);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= in_valid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         b_ff  <= b_in;
         a_ff  <= a_in;
         a3_ff <= a3_in;
      end
      if (rdy2 && vld1_ff) begin
         a2_ff  <= a2_in;
         b2_ff  <= b2_in;
         ab3_ff <= ab3_in;
         a2s_ff <= a_ff;
         b2s_ff <= b_ff;
      end
      if (rdy3 && vld2_ff) begin
         w_ff <= w_in;
      end
   end

   assign out_valid = vld3_ff;
   assign weights   = w_ff;

endmodule

FILE: hw/rtl/cbez_mac.sv
// Weighted sum of control points per coordinate: products, then sum (two stages).
module cbez_mac
   import cbez_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  weights_type  weights,
   input  ctrl_pts_type ctrl,
   output logic         out_valid,
   input  logic         out_ready,
   output num_pair_type num
);

   logic                    vld1_ff, vld2_ff;
   logic                    rdy1, rdy2;
   logic signed [P_W-1:0]   p_in [LANE_N][PT_N];
   logic signed [P_W-1:0]   p_ff [LANE_N][PT_N];
   num_pair_type            num_in, num_ff;

   // Stall chain
   assign rdy2     = !vld2_ff || out_ready;
   assign rdy1     = !vld1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: weight times control coordinate
   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         for (int k = 0; k < PT_N; k++) begin
            p_in[l][k] = $signed({1'b0, weights[k]}) * $signed(ctrl[l][k]);
         end
      end
   end

   // Stage 2: sum of the four products
   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         num_in[l] = NUM_W'(p_ff[l][0]) + NUM_W'(p_ff[l][1])
                   + NUM_W'(p_ff[l][2]) + NUM_W'(p_ff[l][3]);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= in_valid;
         if (rdy2) vld2_ff <= vld1_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         p_ff <= p_in;
      end
      if (rdy2 && vld1_ff) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = vld2_ff;
   assign num       = num_ff;

endmodule

FILE: hw/rtl/cbez_round.sv
// Round-half-up divide by STEPS^3 via shift and reciprocal multiply (four stages).
module cbez_round
   import cbez_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  num_pair_type num,
   output logic         out_valid,
   input  logic         out_ready,
   output point_type    point
);

   logic                  vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic                  rdy1, rdy2, rdy3, rdy4;
   logic signed [T_W-1:0] t_num [LANE_N];
   logic signed [T_W-1:0] t_sh  [LANE_N];
   logic signed [T_W-1:0] t_off [LANE_N];
   logic [M_W-1:0]        m_in  [LANE_N];
   logic [M_W-1:0]        m1_ff [LANE_N];
   logic [M_W-1:0]        m2_ff [LANE_N];
   logic [M_W-1:0]        m3_ff [LANE_N];
   logic [M_W+R_W-1:0]    rp    [LANE_N];
   logic [Q_W-1:0]        qe_in [LANE_N];
   logic [Q_W-1:0]        qe2_ff [LANE_N];
   logic [Q_W-1:0]        qe3_ff [LANE_N];
   logic [QR_W-1:0]       qr_in [LANE_N];
   logic [QR_W-1:0]       qr_ff [LANE_N];
   logic [M_W-1:0]        rem   [LANE_N];
   logic [Q_W-1:0]        q_fix [LANE_N];
   point_type             pt_in, pt_ff;

   // Stall chain
   assign rdy4     = !vld4_ff || out_ready;
   assign rdy3     = !vld3_ff || rdy4;
   assign rdy2     = !vld2_ff || rdy3;
   assign rdy1     = !vld1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: 2n + den, drop the power-of-two factor, bias to non-negative
   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         t_num[l] = $signed({num[l], 1'b0}) + $signed(T_W'(DEN));
         t_sh[l]  = t_num[l] >>> DIV_SHIFT;
         t_off[l] = t_sh[l] + $signed(T_W'(Q_OFF));
         m_in[l]  = t_off[l][M_W-1:0];
      end
   end

   // Stage 2: quotient estimate, low by at most one
   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         rp[l]    = m1_ff[l] * R_W'(RECIP);
         qe_in[l] = Q_W'(rp[l] >> M_W);
      end
   end

   // Stage 3: back-multiply the estimate
   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         qr_in[l] = qe2_ff[l] * ODD_W'(DIV_ODD);
      end
   end

   // Stage 4: correct by one, remove the bias
   always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
         rem[l] = m3_ff[l] - M_W'(qr_ff[l]);
         if (rem[l] >= M_W'(DIV_ODD)) begin
            q_fix[l] = qe3_ff[l] + Q_W'(1);
         end else begin
            q_fix[l] = qe3_ff[l];
         end
         pt_in[l] = COORD_W'(q_fix[l] - Q_W'(Q_BIAS));
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= in_valid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
         if (rdy4) vld4_ff <= vld3_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         m1_ff <= m_in;
      end
      if (rdy2 && vld1_ff) begin
         m2_ff  <= m1_ff;
         qe2_ff <= qe_in;
      end
      if (rdy3 && vld2_ff) begin
         m3_ff  <= m2_ff;
         qe3_ff <= qe2_ff;
         qr_ff  <= qr_in;
      end
      if (rdy4 && vld3_ff) begin
         pt_ff <= pt_in;
      end
   end

   assign out_valid = vld4_ff;
   assign point     = pt_ff;

   // Reciprocal estimate is never off by more than one
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> (rem[0] < M_W'(2 * DIV_ODD)) && (rem[1] < M_W'(2 * DIV_ODD)))
      else $error("rounding remainder out of range");

   // Corrected quotient stays inside the biased coordinate range
   a_q_range: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> (q_fix[0] < Q_W'(2 * Q_BIAS)) && (q_fix[1] < Q_W'(2 * Q_BIAS)))
      else $error("rounded quotient overflows coordinate");

   // A stalled last stage holds its word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld4_ff && !out_ready |=> vld4_ff && $stable(pt_ff))
      else $error("last stage lost a stalled word");

endmodule

FILE: bench/cbez_checker.sv
// Point checker for the cubic Bezier evaluator: predicts every point and compares.
`timescale 1ns / 1ps
module cbez_checker
   import cbez_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] step_index
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [31:0]          rsp_tdata,   // [15:0] point_x, [31:16] point_y
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data,
   output int                   pending,
   output int                   fail_count
);

   localparam int CTRL_REG_N = 8;
   localparam int REPORT_MAX = 10;

   // same bit layout as rsp_tdata: x low, y high
   typedef struct packed {
      coord_type y;
      coord_type x;
   } bez_point_type;

   typedef struct packed {
      logic [7:0]    step;
      bez_point_type pt;
   } point_due_type;

   coord_type     ctrl_reg [CTRL_REG_N];
   point_due_type points_due [$];
   int            reported;

   initial begin
      pending    = 0;
      fail_count = 0;
      reported   = 0;
      foreach (ctrl_reg[k]) ctrl_reg[k] = '0;
   end

   // weighted sum over S^3, rounded to nearest with halves going up
   function automatic coord_type blend_coord(input longint w0, input longint w1,
                                             input longint w2, input longint w3,
                                             input coord_type c0, input coord_type c1,
                                             input coord_type c2, input coord_type c3);
      longint twice_num;
      longint twice_den;
      longint q;
      twice_num = 2 * (w0 * c0 + w1 * c1 + w2 * c2 + w3 * c3) + DEN;
      twice_den = 2 * DEN;
      // floor division; the plain divide truncates toward zero
      if (twice_num >= 0)
         q = twice_num / twice_den;
      else
         q = -((-twice_num + twice_den - 1) / twice_den);
      return coord_type'(q[COORD_W-1:0]);
   endfunction

   function automatic bez_point_type curve_point(input logic [7:0] step);
      longint        b;
      longint        a;
      longint        w0, w1, w2, w3;
      bez_point_type p;
      // indexes past the end clamp to the curve end point
      b = longint'(step);
      if (b > STEPS) b = STEPS;
      a  = STEPS - b;
      w0 = a * a * a;
      w1 = 3 * b * a * a;
      w2 = 3 * b * b * a;
      w3 = b * b * b;
      p.x = blend_coord(w0, w1, w2, w3, ctrl_reg[CSR_CTRL_X0], ctrl_reg[CSR_CTRL_X1],
                        ctrl_reg[CSR_CTRL_X2], ctrl_reg[CSR_CTRL_X3]);
      p.y = blend_coord(w0, w1, w2, w3, ctrl_reg[CSR_CTRL_Y0], ctrl_reg[CSR_CTRL_Y1],
                        ctrl_reg[CSR_CTRL_Y2], ctrl_reg[CSR_CTRL_X3_Y]);
      return p;
   endfunction

   task automatic report_fault(input string msg);
      fail_count++;
      if (reported < REPORT_MAX) begin
         reported++;
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin : watch
      bez_point_type got;
      point_due_type want;
      if (reset) begin
         foreach (ctrl_reg[k]) ctrl_reg[k] = '0;
         points_due.delete();
      end else begin
         // track register writes; indexes past the file are dropped
         if (csr_valid && csr_ready && csr_index < CTRL_REG_N)
            ctrl_reg[csr_index] = csr_data;

         // predict one point per accepted step word
         if (req_tvalid && req_tready)
            points_due.push_back({req_tdata, curve_point(req_tdata)});

         // compare each accepted point word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (points_due.size() == 0) begin
               report_fault($sformatf("unexpected point word x=%0d y=%0d", got.x, got.y));
            end else begin
               want = points_due.pop_front();
               if (got.x !== want.pt.x)
                  report_fault($sformatf("point_x at step %0d: expected %0d, got %0d",
                                         want.step, want.pt.x, got.x));
               if (got.y !== want.pt.y)
                  report_fault($sformatf("point_y at step %0d: expected %0d, got %0d",
                                         want.step, want.pt.y, got.y));
            end
         end
      end
      pending <= points_due.size();
   end

endmodule

FILE: bench/testbench.sv
// Stimulus and verdict for the cubic Bezier point evaluator.
`timescale 1ns / 1ps
module testbench
   import cbez_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_PAST_END  = 4'd8;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_INDEX = 4'hF;
   localparam int CTRL_REG_N   = 8;
   localparam int PHASE_N      = 8;
   localparam int PHASE_ITEMS  = 92;
   localparam int PRESS_PHASE  = 3;
   localparam int PRESS_CYCLES = 150;
   localparam int TAIL_CYCLES  = 20;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_data;

   int pending;
   int fail_count;
   int calm_req;
   int calm_rsp;
   int rsp_hold;

   logic [7:0] corner_steps [13] = '{8'd0, 8'd1, 8'd2, 8'd85, 8'd100, 8'd127, 8'd128,
                                     8'd170, 8'd199, 8'd200, 8'd201, 8'd254, 8'd255};

   cubic_bezier_point_eval u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cbez_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // bound the run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // point receiver: random stalls, calm stretches and one long hold-off
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = calm_rsp ? 0 : $urandom_range(0, 19);
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return '0;
         3:       return COORD_W'($urandom_range(0, 200) - 100);
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_step();
      case ($urandom_range(0, 11))
         0:       return 8'($urandom_range(STEPS + 1, 255));
         1:       return 8'(STEPS);
         2:       return '0;
         default: return 8'($urandom_range(0, STEPS - 1));
      endcase
   endfunction

   task automatic send_step(input logic [7:0] step);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= step;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drop valid and hold until every predicted point has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   initial begin
      calm_req   = 0;
      calm_rsp   = 0;
      rsp_hold   = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: every point sits at the origin
      send_step(8'd0);
      send_step(8'd100);
      send_step(8'd200);
      send_step(8'd255);
      drain();

      // alternating extremes on the control polygon
      csr_write(CSR_CTRL_X0, 16'h8000);
      csr_write(CSR_CTRL_Y0, 16'h7FFF);
      csr_write(CSR_CTRL_X1, 16'h7FFF);
      csr_write(CSR_CTRL_Y1, 16'h8000);
      csr_write(CSR_CTRL_X2, 16'h8000);
      csr_write(CSR_CTRL_Y2, 16'h7FFF);
      csr_write(CSR_CTRL_X3, 16'h7FFF);
      csr_write(CSR_CTRL_X3_Y, 16'h8000);
      // writes past the register file must be dropped
      csr_write(CSR_PAST_END, 16'h1234);
      csr_write(CSR_TOP_INDEX, 16'hEDCB);
      foreach (corner_steps[k]) send_step(corner_steps[k]);
      drain();

      // random phases, each with a fresh control polygon
      for (int phase = 0; phase < PHASE_N; phase++) begin
         calm_req = ($urandom_range(0, 2) == 0);
         calm_rsp = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < CTRL_REG_N; k++) begin
            if (phase == 0)
               csr_write(CSR_IDX_W'(k), 16'h8000);
            else if (phase == 1)
               csr_write(CSR_IDX_W'(k), 16'h7FFF);
            else
               csr_write(CSR_IDX_W'(k), pick_coord());
         end
         if ($urandom_range(0, 1))
            csr_write(CSR_PAST_END | CSR_IDX_W'($urandom_range(0, 7)), pick_coord());
         // fill the pipeline against a stalled receiver
         if (phase == PRESS_PHASE) begin
            calm_req = 1;
            rsp_hold = PRESS_CYCLES;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_step(pick_step());
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
